// File: rtl/rfdc_pkg.sv
// Shared types, constants and functions for the frame descramble / CRC / reframe block.
// No dependencies; rfdc_ctrl, rfdc_dp and the top level use this package.
package rfdc_pkg;

  localparam int FrameLen   = 18;
  localparam int DataLen    = 16;
  localparam int PayloadLen = 15;
  localparam int OutLen     = 20;

  localparam logic [4:0]  POS_SEQ_KEY  = 5'd0;
  localparam logic [4:0]  POS_CRC_LOW  = 5'd16;
  localparam logic [4:0]  POS_CRC_HIGH = 5'd17;
  localparam logic [4:0]  POS_DONE     = 5'd18;

  localparam logic [4:0]  IDX_HDR0     = 5'd0;
  localparam logic [4:0]  IDX_HDR1     = 5'd1;
  localparam logic [4:0]  IDX_HDR2     = 5'd2;
  localparam logic [4:0]  IDX_PAY_LAST = 5'd17;
  localparam logic [4:0]  IDX_CRC_LOW  = 5'd18;
  localparam logic [4:0]  IDX_CRC_HIGH = 5'd19;

  localparam logic [15:0] CRC_INIT = 16'h5555;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  HDR0     = 8'hAA;
  localparam logic [7:0]  HDR1     = 8'h55;
  localparam logic [7:0]  HDR2     = 8'h11;

  localparam logic [1:0]  ST_FWD   = 2'd0;
  localparam logic [1:0]  ST_CRC   = 2'd1;
  localparam logic [1:0]  ST_DUP   = 2'd2;

  localparam logic [7:0] WHITEN_A [FrameLen] = '{
    8'h57, 8'hA1, 8'h3D, 8'hA7, 8'h66, 8'hB0, 8'h75, 8'h31, 8'h11,
    8'h48, 8'h96, 8'h77, 8'hF8, 8'hE3, 8'h46, 8'hE9, 8'hAB, 8'hD0
  };
  localparam logic [7:0] WHITEN_B [FrameLen] = '{
    8'hEF, 8'hF0, 8'hC7, 8'h8D, 8'hD2, 8'h57, 8'hA1, 8'h3D, 8'hA7,
    8'h66, 8'hB0, 8'h75, 8'h31, 8'h11, 8'h48, 8'h96, 8'h77, 8'hF8
  };
  localparam logic [7:0] KEY_TABLE [DataLen] = '{
    8'h41, 8'h92, 8'h53, 8'h2A, 8'hFC, 8'hAB, 8'hCE, 8'h26,
    8'h0D, 8'h1E, 8'h99, 8'h78, 8'h00, 8'h22, 8'h99, 8'hDE
  };

  typedef enum logic [0:0] {
    S_TAKE,
    S_SEND
  } rfdc_state_t;

  typedef enum logic [1:0] {
    OSEL_STREAM,
    OSEL_CRC_ERR,
    OSEL_DUP
  } rfdc_osel_t;

  typedef struct packed {
    logic       take;
    logic       load_out;
    rfdc_osel_t sel;
    logic [4:0] idx;
    logic       commit;
  } rfdc_cmd_t;

  typedef struct packed {
    logic active;
    logic is_last_byte;
    logic crc_ok;
    logic dup;
    logic out_valid;
  } rfdc_stat_t;

  // Whitening mask for a frame position; key added below 16, zero from 18.
  function automatic logic [7:0] descr_mask(input logic [4:0] pos);
    logic [7:0] m;
    m = 8'h00;
    if (pos < POS_DONE) begin
      m = WHITEN_A[pos] ^ WHITEN_B[pos];
      if (pos < POS_CRC_LOW) begin
        m = m ^ KEY_TABLE[pos[3:0]];
      end
    end
    return m;
  endfunction

  // CRC-16, MSB first, one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int n = 0; n < 8; n++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/rfdc_if.sv
// Valid/ready channel interfaces for the input bytes and the result items.
// Depends on nothing.
interface rfdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface rfdc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// File: rtl/rfdc_ctrl.sv
// Controller: takes frame bytes, decides the verdict on the final byte and
// sequences the 20-item reframed output. Depends on rfdc_pkg.
module rfdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  rfdc_pkg::rfdc_stat_t stat,
  output rfdc_pkg::rfdc_cmd_t  cmd
);

  rfdc_pkg::rfdc_state_t state_r, state_nxt;
  logic [4:0]            idx_r, idx_nxt;
  logic                  out_free;

  assign out_free = !stat.out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rfdc_pkg::S_TAKE;
      idx_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    in_ready     = 1'b0;
    cmd.take     = 1'b0;
    cmd.load_out = 1'b0;
    cmd.sel      = rfdc_pkg::OSEL_STREAM;
    cmd.idx      = idx_r;
    cmd.commit   = 1'b0;
    unique case (state_r)
      rfdc_pkg::S_TAKE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          cmd.take = 1'b1;
          if (stat.active && stat.is_last_byte) begin
            if (!stat.crc_ok) begin
              cmd.load_out = 1'b1;
              cmd.sel      = rfdc_pkg::OSEL_CRC_ERR;
            end else if (stat.dup) begin
              cmd.load_out = 1'b1;
              cmd.sel      = rfdc_pkg::OSEL_DUP;
            end else begin
              cmd.commit = 1'b1;
              idx_nxt    = 5'd0;
              state_nxt  = rfdc_pkg::S_SEND;
            end
          end
        end
      end
      rfdc_pkg::S_SEND: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          if (idx_r == rfdc_pkg::IDX_CRC_HIGH) begin
            idx_nxt   = 5'd0;
            state_nxt = rfdc_pkg::S_TAKE;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      default: begin
        state_nxt = rfdc_pkg::S_TAKE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_take_while_send: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rfdc_pkg::S_SEND) |-> !in_ready)
    else $error("input taken while result stream drains");
  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("output register overwritten before it was taken");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= rfdc_pkg::IDX_CRC_HIGH)
    else $error("output index out of range");
  a_send_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rfdc_pkg::S_SEND && cmd.load_out && idx_r == rfdc_pkg::IDX_CRC_HIGH)
      |=> (state_r == rfdc_pkg::S_TAKE))
    else $error("stream did not end after final item");
`endif

endmodule

// File: rtl/rfdc_dp.sv
// Datapath: descrambling, running CRCs, payload store, sequence check and the
// output register. Depends on rfdc_pkg.
module rfdc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_start,
  input  logic                 out_ready,
  input  rfdc_pkg::rfdc_cmd_t  cmd,
  output rfdc_pkg::rfdc_stat_t stat,
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic [1:0]           status,
  output logic                 last
);

  logic [4:0]  byte_pos_r;
  logic [7:0]  seq_key_r;
  logic [15:0] check_crc_r;
  logic [7:0]  rx_crc_low_r;
  logic [7:0]  last_seq_r;
  logic        seq_seen_r;
  logic [15:0] out_crc_r;
  logic [7:0]  payload_mem [rfdc_pkg::PayloadLen];

  logic        out_valid_r;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        last_r, last_nxt;

  logic [4:0]  pos;
  logic [7:0]  d_white;
  logic [7:0]  d_keyed;
  logic [3:0]  wr_addr;
  logic [3:0]  rd_off;
  logic        pay_rd;

  assign pos     = frame_start ? rfdc_pkg::POS_SEQ_KEY : byte_pos_r;
  assign d_white = rx_byte ^ rfdc_pkg::descr_mask(pos);
  assign d_keyed = d_white ^ seq_key_r;
  assign wr_addr = 4'(pos - 5'd1);
  assign rd_off  = 4'(cmd.idx - 5'd3);
  assign pay_rd  = (cmd.sel == rfdc_pkg::OSEL_STREAM) &&
                   (cmd.idx > rfdc_pkg::IDX_HDR2) &&
                   (cmd.idx <= rfdc_pkg::IDX_PAY_LAST);

  assign stat.active       = (pos < rfdc_pkg::POS_DONE);
  assign stat.is_last_byte = (pos == rfdc_pkg::POS_CRC_HIGH);
  assign stat.crc_ok       = ({d_white, rx_crc_low_r} == check_crc_r);
  assign stat.dup          = seq_seen_r && (last_seq_r == seq_key_r);
  assign stat.out_valid    = out_valid_r;

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r   <= 5'd0;
      seq_key_r    <= 8'h00;
      check_crc_r  <= rfdc_pkg::CRC_INIT;
      rx_crc_low_r <= 8'h00;
      last_seq_r   <= 8'h00;
      seq_seen_r   <= 1'b0;
      out_crc_r    <= rfdc_pkg::CRC_INIT;
    end else begin
      if (cmd.take && stat.active) begin
        byte_pos_r <= pos + 5'd1;
        if (pos == rfdc_pkg::POS_SEQ_KEY) begin
          seq_key_r   <= d_white;
          check_crc_r <= rfdc_pkg::crc_byte(rfdc_pkg::CRC_INIT, d_white);
          out_crc_r   <= rfdc_pkg::crc_byte(rfdc_pkg::CRC_INIT, rfdc_pkg::HDR2);
        end else if (pos < rfdc_pkg::POS_CRC_LOW) begin
          check_crc_r <= rfdc_pkg::crc_byte(check_crc_r, d_keyed);
          out_crc_r   <= rfdc_pkg::crc_byte(out_crc_r, d_keyed);
        end else if (pos == rfdc_pkg::POS_CRC_LOW) begin
          rx_crc_low_r <= d_white;
        end
      end
      if (cmd.commit) begin
        last_seq_r <= seq_key_r;
        seq_seen_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && stat.active && pos != rfdc_pkg::POS_SEQ_KEY &&
        pos < rfdc_pkg::POS_CRC_LOW) begin
      payload_mem[wr_addr] <= d_keyed;
    end
  end

  // Output item selection; payload bytes come straight from the store at load
  always_comb begin
    out_byte_nxt = 8'h00;
    last_nxt     = 1'b1;
    status_nxt   = rfdc_pkg::ST_FWD;
    unique case (cmd.sel)
      rfdc_pkg::OSEL_CRC_ERR: status_nxt = rfdc_pkg::ST_CRC;
      rfdc_pkg::OSEL_DUP:     status_nxt = rfdc_pkg::ST_DUP;
      rfdc_pkg::OSEL_STREAM: begin
        last_nxt = (cmd.idx == rfdc_pkg::IDX_CRC_HIGH);
        if (cmd.idx == rfdc_pkg::IDX_HDR0) begin
          out_byte_nxt = rfdc_pkg::HDR0;
        end else if (cmd.idx == rfdc_pkg::IDX_HDR1) begin
          out_byte_nxt = rfdc_pkg::HDR1;
        end else if (cmd.idx == rfdc_pkg::IDX_HDR2) begin
          out_byte_nxt = rfdc_pkg::HDR2;
        end else if (cmd.idx <= rfdc_pkg::IDX_PAY_LAST) begin
          out_byte_nxt = 8'h00;
        end else if (cmd.idx == rfdc_pkg::IDX_CRC_LOW) begin
          out_byte_nxt = out_crc_r[7:0];
        end else begin
          out_byte_nxt = out_crc_r[15:8];
        end
      end
      default: status_nxt = rfdc_pkg::ST_FWD;
    endcase
  end

  // Output register: load on command, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte_r <= pay_rd ? payload_mem[rd_off] : out_byte_nxt;
      status_r   <= status_nxt;
      last_r     <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign status    = status_r;
  assign last      = last_r;

endmodule

// File: rtl/rf_frame_descramble_crc_reframe.sv
// Top level of the radio frame descramble / CRC check / reframe block.
// Depends on rfdc_pkg, rfdc_if, rfdc_ctrl and rfdc_dp.
//
// Usage:
//   in_ch carries one received byte per item (rx_byte) with frame_start set
//   on byte 0 of each 18-byte frame. Bytes are descrambled and checked as
//   they arrive; bytes 0 to 16 produce nothing and are taken one per cycle
//   while the output register is free. On byte 17 the block either emits
//   one status item (CRC mismatch or duplicate sequence, out_byte 0, last 1)
//   or 20 forwarded bytes: AA 55 11, the 15 payload bytes, then the output
//   CRC low byte first, with last set on the 20th.
//   A status item is offered in the cycle after byte 17 is taken; the first
//   forwarded byte passes the send state, then the output register.
//   Throughput: one input byte per cycle while the output register is
//   free; after a good frame the input is held while the sequencer walks
//   the output bytes through the single output register, one per cycle while it is free.
//   out_ch stalls hold the output register and, through it, the input.
//   Bytes after the 18th are dropped until the next frame_start.
//   Reset (rst_n low, synchronous) clears the frame position, the sequence
//   history and both CRCs; the first byte after reset counts as byte 0.
module rf_frame_descramble_crc_reframe (
  input  logic        clk,
  input  logic        rst_n,
  rfdc_in_if.sink     in_ch,
  rfdc_out_if.source  out_ch
);

  rfdc_pkg::rfdc_cmd_t  cmd;
  rfdc_pkg::rfdc_stat_t stat;

  rfdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rfdc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_byte    (out_ch.out_byte),
    .status      (out_ch.status),
    .last        (out_ch.last)
  );

endmodule
